@@ sv/dwt_db2_pkg.sv @@
// ----------------------------------------------------------------------------
// dwt_db2_pkg
// Shared types, widths and coefficient helpers for the db2 analysis block.
// ----------------------------------------------------------------------------
package dwt_db2_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 15;
  localparam int OUT_BITS           = 18;
  localparam int QUEUE_DEPTH        = 4;
  localparam int KIND_BITS          = 2;

  localparam longint unsigned MAG_C1 = 64'd12941;
  localparam longint unsigned MAG_C2 = 64'd22414;
  localparam longint unsigned MAG_C3 = 64'd83652;
  localparam longint unsigned MAG_C4 = 64'd48296;

  typedef enum logic [KIND_BITS-1:0] {
    JOB_ONE      = 2'd0,
    JOB_SHORT    = 2'd1,
    JOB_END_ODD  = 2'd2,
    JOB_END_EVEN = 2'd3
  } job_kind_t;

  function automatic longint unsigned qcoef(input int frac, input longint unsigned mag);
    return ((mag << frac) + 64'd50000) / 64'd100000;
  endfunction

endpackage

@@ sv/dwt_db2_analysis.sv @@
// ----------------------------------------------------------------------------
// dwt_db2_analysis
// One level of db2 wavelet analysis on blocks of signed samples.
// ----------------------------------------------------------------------------
// A coefficient pair passes the job queue and the tap, product, sum and result
// registers. Throughput: one sample per cycle unless a full job queue stalls;
// a block-end sample after two earlier samples yields two pairs from the
// single shared filter pipeline; a 4-entry job queue absorbs output stalls.
// Reset: synchronous; clears block state, the job queue and all valid flags.
// ----------------------------------------------------------------------------
module dwt_db2_analysis #(
  parameter int SAMPLE_BITS    = dwt_db2_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = dwt_db2_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        sample_valid,
  output logic                                        sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]               sample,
  input  logic                                        end_of_block,
  output logic                                        result_valid,
  input  logic                                        result_stall,
  output logic signed [dwt_db2_pkg::OUT_BITS-1:0]     approx,
  output logic signed [dwt_db2_pkg::OUT_BITS-1:0]     detail,
  output logic                                        final_result,
  output logic                                        too_short
);

  localparam int JOB_BITS = dwt_db2_pkg::KIND_BITS + 4 * SAMPLE_BITS;

  logic                q_full, q_empty, q_push, q_pop;
  logic [JOB_BITS-1:0] q_data, q_head;

  dwt_db2_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .end_of_block (end_of_block),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  dwt_db2_queue #(
    .WIDTH (JOB_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  dwt_db2_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_head       (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .approx       (approx),
    .detail       (detail),
    .final_result (final_result),
    .too_short    (too_short)
  );

endmodule

@@ sv/dwt_db2_front.sv @@
// ----------------------------------------------------------------------------
// dwt_db2_front
// Accepts samples, tracks the sample window and block phase, and turns each
// sample that yields coefficients into a job for the filter back end.
// ----------------------------------------------------------------------------
module dwt_db2_front #(
  parameter int SAMPLE_BITS = dwt_db2_pkg::SAMPLE_BITS_DEF,
  localparam int JOB_BITS   = dwt_db2_pkg::KIND_BITS + 4 * SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          end_of_block,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [JOB_BITS-1:0]           q_data
);

  logic signed [SAMPLE_BITS-1:0] w0, w1, w2;
  logic [1:0]                    seen_count;
  logic                          phase;
  logic                          accept;
  dwt_db2_pkg::job_kind_t        kind;
  logic signed [SAMPLE_BITS-1:0] t0, t1, t2, t3;

  assign sample_stall = q_full;
  assign accept       = sample_valid && !q_full;
  assign q_push       = accept && (end_of_block || phase);

  always_comb begin
    kind = dwt_db2_pkg::JOB_ONE;
    t0   = w2;
    t1   = w1;
    t2   = w0;
    t3   = sample;
    if (end_of_block) begin
      if (seen_count < 2'd2) begin
        kind = dwt_db2_pkg::JOB_SHORT;
      end else if (phase) begin
        kind = dwt_db2_pkg::JOB_END_ODD;
      end else begin
        kind = dwt_db2_pkg::JOB_END_EVEN;
      end
    end else if (seen_count == 2'd1) begin
      t0 = sample;
      t1 = w0;
      t2 = w0;
    end
  end

  assign q_data = {kind, t0, t1, t2, t3};

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= 2'd0;
      phase      <= 1'b0;
    end else if (accept) begin
      if (end_of_block) begin
        seen_count <= 2'd0;
        phase      <= 1'b0;
      end else begin
        if (seen_count != 2'd3) begin
          seen_count <= seen_count + 2'd1;
        end
        phase <= ~phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w2 <= w1;
      w1 <= w0;
      w0 <= sample;
    end
  end

endmodule

@@ sv/dwt_db2_queue.sv @@
// ----------------------------------------------------------------------------
// dwt_db2_queue
// Small register FIFO that holds filter jobs between front and back end.
// ----------------------------------------------------------------------------
module dwt_db2_queue #(
  parameter int WIDTH = 8,
  localparam int DEPTH  = dwt_db2_pkg::QUEUE_DEPTH,
  localparam int PTR_W  = $clog2(DEPTH),
  localparam int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ sv/dwt_db2_back.sv @@
// ----------------------------------------------------------------------------
// dwt_db2_back
// Expands jobs into tap sets and runs the pipelined low-pass and high-pass
// filters with rounding, saturation and a registered result.
// ----------------------------------------------------------------------------
module dwt_db2_back #(
  parameter int SAMPLE_BITS    = dwt_db2_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = dwt_db2_pkg::COEF_FRAC_BITS_DEF,
  localparam int JOB_BITS      = dwt_db2_pkg::KIND_BITS + 4 * SAMPLE_BITS,
  localparam int OW            = dwt_db2_pkg::OUT_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [JOB_BITS-1:0]  q_head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic signed [OW-1:0] approx,
  output logic signed [OW-1:0] detail,
  output logic                 final_result,
  output logic                 too_short
);

  localparam int SB    = SAMPLE_BITS;
  localparam int CW    = COEF_FRAC_BITS + 2;
  localparam int PW    = SB + CW;
  localparam int ACC_W = PW + 2;

  localparam logic signed [CW-1:0] C1 =
    CW'(dwt_db2_pkg::qcoef(COEF_FRAC_BITS, dwt_db2_pkg::MAG_C1));
  localparam logic signed [CW-1:0] C2 =
    CW'(dwt_db2_pkg::qcoef(COEF_FRAC_BITS, dwt_db2_pkg::MAG_C2));
  localparam logic signed [CW-1:0] C3 =
    CW'(dwt_db2_pkg::qcoef(COEF_FRAC_BITS, dwt_db2_pkg::MAG_C3));
  localparam logic signed [CW-1:0] C4 =
    CW'(dwt_db2_pkg::qcoef(COEF_FRAC_BITS, dwt_db2_pkg::MAG_C4));

  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (OW - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(1 << (OW - 1));

  dwt_db2_pkg::job_kind_t        kind;
  logic signed [SB-1:0]          e0, e1, e2, e3;
  logic signed [SB-1:0]          x0, x1, x2, x3;
  logic                          sel_fin, sel_short, two_beats;
  logic                          en, sub;

  logic                          v1, fin1, short1;
  logic signed [SB-1:0]          r0, r1, r2, r3;
  logic                          v2, fin2, short2;
  logic signed [PW-1:0]          pa0, pa1, pa2, pa3, pd0, pd1, pd2, pd3;
  logic                          v3, fin3, short3;
  logic signed [PW:0]            sa01, sa23, sd01, sd23;

  logic signed [ACC_W-1:0]       acc_a, acc_d, sh_a, sh_d;
  logic signed [OW-1:0]          approx_next, detail_next;

  assign kind = dwt_db2_pkg::job_kind_t'(q_head[JOB_BITS-1 -: dwt_db2_pkg::KIND_BITS]);
  assign e0   = q_head[4*SB-1 -: SB];
  assign e1   = q_head[3*SB-1 -: SB];
  assign e2   = q_head[2*SB-1 -: SB];
  assign e3   = q_head[SB-1:0];

  assign en        = !(result_valid && result_stall);
  assign two_beats = (kind == dwt_db2_pkg::JOB_END_ODD) ||
                     (kind == dwt_db2_pkg::JOB_END_EVEN);
  assign q_pop     = en && !q_empty && (!two_beats || sub);

  always_comb begin
    x0        = e0;
    x1        = e1;
    x2        = e2;
    x3        = e3;
    sel_fin   = 1'b0;
    sel_short = 1'b0;
    unique case (kind)
      dwt_db2_pkg::JOB_ONE: begin
      end
      dwt_db2_pkg::JOB_SHORT: begin
        x0        = '0;
        x1        = '0;
        x2        = '0;
        x3        = '0;
        sel_fin   = 1'b1;
        sel_short = 1'b1;
      end
      dwt_db2_pkg::JOB_END_ODD: begin
        if (sub) begin
          x0      = e2;
          x1      = e3;
          x2      = e3;
          x3      = e2;
          sel_fin = 1'b1;
        end
      end
      dwt_db2_pkg::JOB_END_EVEN: begin
        if (sub) begin
          x0      = e3;
          x1      = e3;
          x2      = e2;
          x3      = e1;
          sel_fin = 1'b1;
        end else begin
          x0 = e1;
          x1 = e2;
          x2 = e3;
          x3 = e3;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub          <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      if (!q_empty && two_beats) begin
        sub <= ~sub;
      end
      v1           <= !q_empty;
      v2           <= v1;
      v3           <= v2;
      result_valid <= v3;
    end
  end

  always_comb begin
    acc_a       = ACC_W'(sa01) + ACC_W'(sa23) + HALF;
    acc_d       = ACC_W'(sd01) + ACC_W'(sd23) + HALF;
    sh_a        = acc_a >>> COEF_FRAC_BITS;
    sh_d        = acc_d >>> COEF_FRAC_BITS;
    approx_next = sh_a[OW-1:0];
    detail_next = sh_d[OW-1:0];
    if (sh_a > SAT_MAX) begin
      approx_next = SAT_MAX[OW-1:0];
    end else if (sh_a < SAT_MIN) begin
      approx_next = SAT_MIN[OW-1:0];
    end
    if (sh_d > SAT_MAX) begin
      detail_next = SAT_MAX[OW-1:0];
    end else if (sh_d < SAT_MIN) begin
      detail_next = SAT_MIN[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0     <= x0;
      r1     <= x1;
      r2     <= x2;
      r3     <= x3;
      fin1   <= sel_fin;
      short1 <= sel_short;

      pa0    <= r0 * C4;
      pa1    <= r1 * C3;
      pa2    <= r2 * C2;
      pa3    <= r3 * C1;
      pd0    <= r0 * C1;
      pd1    <= r1 * C2;
      pd2    <= r2 * C3;
      pd3    <= r3 * C4;
      fin2   <= fin1;
      short2 <= short1;

      sa01   <= (PW+1)'(pa0) + (PW+1)'(pa1);
      sa23   <= (PW+1)'(pa2) - (PW+1)'(pa3);
      sd01   <= -(PW+1)'(pd0) - (PW+1)'(pd1);
      sd23   <= (PW+1)'(pd2) - (PW+1)'(pd3);
      fin3   <= fin2;
      short3 <= short2;

      approx       <= approx_next;
      detail       <= detail_next;
      final_result <= fin3;
      too_short    <= short3;
    end
  end

endmodule
